// ===== hw/rtl/aprs_pkg.sv =====
// Package for the position report parser: field codes, frame kinds and
// sequencer states. No dependencies.
package aprs_pkg;

  typedef enum logic [3:0] {
    FC_CALL  = 4'd0,
    FC_DEST  = 4'd1,
    FC_TIME  = 4'd2,
    FC_LAT   = 4'd3,
    FC_LON   = 4'd4,
    FC_SYM   = 4'd5,
    FC_CRS   = 4'd6,
    FC_SPD   = 4'd7,
    FC_ALT   = 4'd8,
    FC_NONE  = 4'd9
  } field_code_t;

  typedef enum logic [2:0] {
    FK_NOCOLON = 3'd0,
    FK_POS     = 3'd1,
    FK_COMP    = 3'd2,
    FK_MSG     = 3'd3,
    FK_STATUS  = 3'd4,
    FK_UNKNOWN = 3'd5
  } frame_kind_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_COLON,
    ST_KIND,
    ST_CALL,
    ST_DEST,
    ST_TYPE,
    ST_TIME,
    ST_LAT,
    ST_LON,
    ST_SYM,
    ST_CHKC,
    ST_CRS,
    ST_SPDV,
    ST_SPDM,
    ST_SPD,
    ST_CHKA,
    ST_ALTV,
    ST_ALTM,
    ST_ALT,
    ST_DONE
  } state_t;

  localparam logic [14:0] SPEED_MAX = 15'd18501;
  localparam logic [18:0] ALT_MAX   = 19'd304799;
  localparam int          MAX_RESULTS = 62;

endpackage

// ===== hw/rtl/aprs_position_report_parser_core.sv =====
// Top level of the position report parser: frame store memory and parse sequencer.
// Depends on aprs_pkg.
//
//  channel | ports                               | handshake
//  input   | in_rx_byte, in_frame_end            | start & !busy
//  result  | out_frame_kind .. out_run_end        | out_valid, one cycle
//
// Loading stores one byte per accepted start. After the last byte the sequencer reads the
// frame store one byte per read (address phase, then registered data phase) and runs the
// arithmetic steps for speed and altitude. busy stays high from the final byte until the
// closing result. Reset clears the byte count, sequencer, out_valid and the phase and
// read-valid flags; the store needs no clearing.
module aprs_position_report_parser_core #(
  parameter int FRAME_BYTES        = 128,
  parameter int COLON_SEARCH_LIMIT = 125,
  parameter int ADDR_CHARS         = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  output logic [2:0]  out_frame_kind,
  output logic [3:0]  out_field_code,
  output logic [7:0]  out_char_value,
  output logic [14:0] out_speed_tenths_kmh,
  output logic [18:0] out_altitude_m,
  output logic        out_run_end
);
  import aprs_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = AW + 1;
  localparam int PW = 10;

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] rd_addr;
  logic          rd_ok_r;

  state_t st_r, st_nxt;
  logic          ph_r, ph_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [4:0]    i_r, i_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [5:0]    nres_r, nres_nxt;
  logic [24:0]   acc_r, acc_nxt;
  logic [14:0]   spd_r, spd_nxt;
  logic [18:0]   alt_r, alt_nxt;
  logic [7:0]    c0_r, c0_nxt;
  logic [7:0]    c1_r, c1_nxt;
  logic [29:0]   prod_r, prod_nxt;

  logic        ov_nxt, ov_r, re_nxt, re_r;
  logic [3:0]  fc_nxt, fc_r;
  logic [7:0]  ch_nxt, ch_r;
  logic [14:0] os_nxt, os_r;
  logic [18:0] oa_nxt, oa_r;

  logic        load;
  logic [7:0]  rb;
  logic [7:0]  dg;
  logic [31:0] prod;
  logic [48:0] spd_mul;
  logic [56:0] alt_mul;
  logic [19:0] spd_q;
  logic [18:0] alt_q;

  assign load = start && !busy;
  assign busy = (st_r != ST_LOAD);
  assign rb = rd_ok_r ? rdata_r : 8'd0;
  assign dg = rb - 8'h30;
  assign prod = {12'd0, acc_r[19:0]} * ((st_r == ST_SPDM) ? 32'd1852 : 32'd3048);
  // Division by 100 and by 10000 through reciprocal multiplication.
  assign spd_mul = {25'd0, prod_r[23:0]} * {24'd0, 25'd21474837};
  assign spd_q = spd_mul[48:29];
  assign alt_mul = {29'd0, prod_r[29:2]} * {28'd0, 29'd439804652};
  assign alt_q = alt_mul[56:38];

  always_ff @(posedge clk) begin
    if (load && cnt_r < CW'(FRAME_BYTES)) begin
      mem[cnt_r[AW-1:0]] <= in_rx_byte;
    end
    rdata_r <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      cnt_r <= '0;
      ov_r <= 1'b0;
      ph_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      ph_r <= ph_nxt;
      rd_ok_r <= ({{(32-PW){1'b0}}, rd_addr} < 32'(FRAME_BYTES)) &&
                 (rd_addr < PW'(cnt_r));
    end
    p_r <= p_nxt; idx_r <= idx_nxt; i_r <= i_nxt; kind_r <= kind_nxt;
    nres_r <= nres_nxt; acc_r <= acc_nxt; spd_r <= spd_nxt; alt_r <= alt_nxt;
    c0_r <= c0_nxt; c1_r <= c1_nxt; prod_r <= prod_nxt;
    fc_r <= fc_nxt; ch_r <= ch_nxt; os_r <= os_nxt; oa_r <= oa_nxt; re_r <= re_nxt;
  end

  assign out_valid = ov_r;
  assign out_frame_kind = kind_r;
  assign out_field_code = fc_r;
  assign out_char_value = ch_r;
  assign out_speed_tenths_kmh = os_r;
  assign out_altitude_m = oa_r;
  assign out_run_end = re_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ph_nxt = 1'b0; p_nxt = p_r; idx_nxt = idx_r;
    i_nxt = i_r; kind_nxt = kind_r; nres_nxt = nres_r; acc_nxt = acc_r;
    spd_nxt = spd_r; alt_nxt = alt_r; c0_nxt = c0_r; c1_nxt = c1_r;
    prod_nxt = prod_r;
    ov_nxt = 1'b0; re_nxt = 1'b0; fc_nxt = fc_r; ch_nxt = ch_r;
    os_nxt = '0; oa_nxt = '0;
    rd_addr = p_r;
    if (load) begin
      rd_addr = '0;
    end
    unique case (st_r)
      ST_LOAD: begin
        if (load) begin
          if (cnt_r < CW'(FRAME_BYTES)) cnt_nxt = cnt_r + 1'b1;
          if (in_frame_end) begin
            if (cnt_r < CW'(FRAME_BYTES)) cnt_nxt = cnt_r + 1'b1;
            st_nxt = ST_COLON; p_nxt = '0; idx_nxt = '0; nres_nxt = '0;
          end
        end
      end
      ST_COLON: begin
        if (!ph_r) ph_nxt = 1'b1;
        else if (rb == ":") begin
          idx_nxt = p_r + 1'b1; p_nxt = p_r + 1'b1; st_nxt = ST_KIND;
        end else if (p_r == PW'(COLON_SEARCH_LIMIT - 1)) begin
          kind_nxt = FK_NOCOLON; p_nxt = '0; i_nxt = '0; st_nxt = ST_CALL;
        end else p_nxt = p_r + 1'b1;
      end
      ST_KIND: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          case (rb)
            "!", "=", "/", "@": kind_nxt = FK_POS;
            8'h27, 8'h60:       kind_nxt = FK_COMP;
            ":":                kind_nxt = FK_MSG;
            ">":                kind_nxt = FK_STATUS;
            default:            kind_nxt = FK_UNKNOWN;
          endcase
          p_nxt = '0; i_nxt = '0; st_nxt = ST_CALL;
        end
      end
      ST_CALL, ST_DEST, ST_TIME, ST_LAT, ST_LON, ST_CRS, ST_SPD, ST_ALT: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          p_nxt = p_r + 1'b1; i_nxt = i_r + 1'b1;
          if ((st_r == ST_CALL && rb == ">") ||
              (st_r == ST_DEST && (rb == ":" || rb == ","))) begin
            i_nxt = '0;
            st_nxt = (st_r == ST_CALL) ? ST_DEST : (kind_r == FK_POS ? ST_TYPE : ST_DONE);
            if (st_r == ST_DEST) p_nxt = idx_r;
          end else begin
            if (nres_r < 6'(MAX_RESULTS - 1)) begin
              ov_nxt = 1'b1; nres_nxt = nres_r + 1'b1; ch_nxt = rb;
              if (st_r == ST_SPD) os_nxt = spd_r;
              if (st_r == ST_ALT) oa_nxt = alt_r;
            end
            unique case (st_r)
              ST_CALL: fc_nxt = FC_CALL;
              ST_DEST: fc_nxt = FC_DEST;
              ST_TIME: fc_nxt = FC_TIME;
              ST_LAT:  fc_nxt = FC_LAT;
              ST_LON:  fc_nxt = FC_LON;
              ST_CRS:  fc_nxt = FC_CRS;
              ST_SPD:  fc_nxt = FC_SPD;
              default: fc_nxt = FC_ALT;
            endcase
            case (st_r)
              ST_CALL: if (i_r == 5'(ADDR_CHARS - 1)) begin
                i_nxt = '0; st_nxt = ST_DEST;
              end
              ST_DEST: if (i_r == 5'(ADDR_CHARS - 1)) begin
                i_nxt = '0; p_nxt = idx_r;
                st_nxt = (kind_r == FK_POS) ? ST_TYPE : ST_DONE;
              end
              ST_TIME: if (i_r == 5'd6) begin i_nxt = '0; st_nxt = ST_LAT; end
              ST_LAT: if (i_r == 5'd7) begin
                i_nxt = '0; p_nxt = p_r + 2'd2; st_nxt = ST_LON;
              end
              ST_LON: if (i_r == 5'd8) begin i_nxt = '0; st_nxt = ST_SYM; end
              ST_CRS: if (i_r == 5'd2) begin
                i_nxt = '0; p_nxt = p_r + 2'd2; acc_nxt = '0; st_nxt = ST_SPDV;
              end
              ST_SPD: if (i_r == 5'd2) begin i_nxt = '0; st_nxt = ST_CHKA; end
              ST_ALT: if (i_r == 5'd5) st_nxt = ST_DONE;
              default: ;
            endcase
          end
        end
      end
      ST_TYPE: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          p_nxt = p_r + 1'b1; i_nxt = '0;
          st_nxt = (rb == "/" || rb == "@") ? ST_TIME : ST_LAT;
        end
      end
      ST_SYM: begin
        rd_addr = p_r + 3'd4;
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          c0_nxt = rb; st_nxt = ST_CHKC;
        end
      end
      ST_CHKC: begin
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          if (nres_r < 6'(MAX_RESULTS - 1)) begin
            ov_nxt = 1'b1; nres_nxt = nres_r + 1'b1;
          end
          fc_nxt = FC_SYM; ch_nxt = rb;
          p_nxt = p_r + 1'b1; i_nxt = '0;
          st_nxt = (rb == "_" || c0_r != "/") ? ST_DONE : ST_CRS;
        end
      end
      ST_SPDV, ST_ALTV: begin
        rd_addr = p_r + PW'(i_r);
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          if (st_r == ST_ALTV && i_r == 5'd0 && rb == "-") begin
            alt_nxt = '0; i_nxt = '0; st_nxt = ST_ALT;
          end else begin
            acc_nxt = 25'(acc_r * 25'd10) + {17'd0, dg};
            i_nxt = i_r + 1'b1;
            if (i_r == ((st_r == ST_SPDV) ? 5'd2 : 5'd5)) begin
              i_nxt = '0; st_nxt = (st_r == ST_SPDV) ? ST_SPDM : ST_ALTM;
            end
          end
        end
      end
      ST_SPDM: begin
        if (!ph_r) begin
          ph_nxt = 1'b1; prod_nxt = prod[31:2];
        end else begin
          spd_nxt = (spd_q > 20'(SPEED_MAX)) ? SPEED_MAX : spd_q[14:0];
          st_nxt = ST_SPD;
        end
      end
      ST_ALTM: begin
        if (!ph_r) begin
          ph_nxt = 1'b1; prod_nxt = prod[31:2];
        end else begin
          alt_nxt = (acc_r >= 25'd1000000) ? ALT_MAX : alt_q;
          st_nxt = ST_ALT;
        end
      end
      ST_CHKA: begin
        rd_addr = p_r + PW'(i_r);
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          if ((i_r == 5'd0 && rb == "/") || (i_r == 5'd1 && rb == "A")) begin
            i_nxt = i_r + 1'b1;
          end else if (i_r == 5'd2 && rb == "=") begin
            i_nxt = '0; p_nxt = p_r + 2'd3; acc_nxt = '0; st_nxt = ST_ALTV;
          end else st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ov_nxt = 1'b1; re_nxt = 1'b1; fc_nxt = FC_NONE; ch_nxt = '0;
        cnt_nxt = '0; st_nxt = ST_LOAD;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

`ifndef SYNTHESIS
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && re_r) |-> (st_r == ST_LOAD)) else $error("run end not followed by idle");
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && re_r) |-> (cnt_r == '0)) else $error("byte count not cleared");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (nres_r <= 6'(MAX_RESULTS - 1))) else $error("result cap exceeded");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_nxt && !re_nxt) |-> busy) else $error("data result while idle");
`endif
endmodule
